// ===== sv/gnfa_pkg.sv =====
package gnfa_pkg;

    localparam int NUM_VERTICES = 1024;
    localparam int FEATURE_LEN  = 16;
    localparam int EMIT_CAP     = 16;
    localparam int NUM_EMIT     = (FEATURE_LEN < EMIT_CAP) ? FEATURE_LEN : EMIT_CAP;

    localparam int NV_W  = $clog2(NUM_VERTICES);
    localparam int FA_W  = $clog2(NUM_VERTICES * FEATURE_LEN);
    localparam int IDX_W = (FEATURE_LEN > 1) ? $clog2(FEATURE_LEN) : 1;
    localparam int CNT_W = $clog2(FEATURE_LEN + 1);

    localparam int FEAT_W = 16;
    localparam int NORM_W = 16;
    localparam int P_W    = 2 * NORM_W;
    localparam int PROD_W = 49;
    localparam int FRAC_SHIFT = 30;
    localparam int TERM_W = PROD_W - FRAC_SHIFT;
    localparam int ACC_W  = 32;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int PADDR_W   = 3;

    typedef enum logic [1:0] {
        ACT_FEATURE = 2'd0,
        ACT_NORM    = 2'd1,
        ACT_GATHER  = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    localparam logic REG_NORM_EN = 1'b0;

endpackage

// ===== sv/gnfa_ram.sv =====
module gnfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/graph_neighbor_feature_aggregate_top.sv =====
// Channel   Dir  Handshake            Contents
// s_        in   s_tvalid/s_tready    one load or gather item
// m_        out  m_tvalid/m_tready    one element of an aggregated row
// apb       in   psel/penable/pready  normalize_enable at address 0
//
// Sequence: a load item is written to its memory as it is taken. A gather with a
// real edge takes the item, reads the two norms and forms their product, streams
// each element through the feature memory, then drains the multiply/round/saturate
// pipeline. A last_edge item adds the accumulator read-out, a read state and a
// write state per element, plus any m_tready stall.
// Reset: aresetn is synchronous, active low; it clears the accumulator valid
// bits, so no clearing pass runs. Feature and norm memories are not cleared.
module graph_neighbor_feature_aggregate_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] vertex_id, [19:10] neighbor_id, [20] has_edge,
    // [24:21] element_index, [41:25] load_value, [47:42] zero
    input  logic [gnfa_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tlast,
    // master result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] out_vertex, [13:10] out_index, [45:14] out_value, [47:46] zero
    output logic [gnfa_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gnfa_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    import gnfa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM_SRC,
        ST_NORM_NBR,
        ST_NORM_MUL,
        ST_ACC,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    state_t state_reg;

    // input item fields
    action_t                in_action;
    logic [9:0]             in_vertex;
    logic [9:0]             in_neighbor;
    logic                   in_has_edge;
    logic [3:0]             in_eidx;
    logic signed [16:0]     in_value;
    logic                   s_accept;

    assign in_action   = action_t'(s_tuser);
    assign in_vertex   = s_tdata[9:0];
    assign in_neighbor = s_tdata[19:10];
    assign in_has_edge = s_tdata[20];
    assign in_eidx     = s_tdata[24:21];
    assign in_value    = s_tdata[41:25];
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;

    // configuration register
    logic norm_en_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_NORM_EN) ? {31'b0, norm_en_reg} : 32'b0;

    // gather item held during its work
    logic [9:0]          vid_reg;
    logic [9:0]          nid_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [NORM_W-1:0]   na_reg;
    logic [P_W-1:0]      p_reg;

    logic in_vid_ok;
    logic in_nid_ok;
    logic in_eidx_ok;
    logic src_ok;

    assign in_vid_ok  = 32'(in_vertex) < NUM_VERTICES;
    assign in_nid_ok  = 32'(in_neighbor) < NUM_VERTICES;
    assign in_eidx_ok = 32'(in_eidx) < FEATURE_LEN;
    assign src_ok     = 32'(vid_reg) < NUM_VERTICES;

    // feature memory
    logic              feat_we;
    logic [FA_W-1:0]   feat_waddr;
    logic              feat_re;
    logic [FA_W-1:0]   feat_raddr;
    logic [FEAT_W-1:0] feat_rdata;

    assign feat_we    = s_accept && (in_action == ACT_FEATURE) && in_vid_ok && in_eidx_ok;
    assign feat_waddr = FA_W'(32'(in_vertex) * FEATURE_LEN + 32'(in_eidx));
    assign feat_raddr = FA_W'(32'(nid_reg) * FEATURE_LEN + 32'(cnt_reg));

    gnfa_ram #(.WIDTH(FEAT_W), .DEPTH(NUM_VERTICES * FEATURE_LEN)) u_feat_ram (
        .aclk  (aclk),
        .we    (feat_we),
        .waddr (feat_waddr),
        .wdata (in_value[FEAT_W-1:0]),
        .re    (feat_re),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    // norm memory
    logic              norm_we;
    logic              norm_re;
    logic [NV_W-1:0]   norm_raddr;
    logic [NORM_W-1:0] norm_rdata;

    assign norm_we = s_accept && (in_action == ACT_NORM) && in_vid_ok;

    gnfa_ram #(.WIDTH(NORM_W), .DEPTH(NUM_VERTICES)) u_norm_ram (
        .aclk  (aclk),
        .we    (norm_we),
        .waddr (NV_W'(in_vertex)),
        .wdata (in_value[NORM_W-1:0]),
        .re    (norm_re),
        .raddr (norm_raddr),
        .rdata (norm_rdata)
    );

    // row accumulator memory, with one valid bit per element
    logic                   acc_we;
    logic [IDX_W-1:0]       acc_waddr;
    logic [ACC_W-1:0]       acc_wdata;
    logic                   acc_re;
    logic [IDX_W-1:0]       acc_raddr;
    logic [ACC_W-1:0]       acc_rdata;
    logic [FEATURE_LEN-1:0] acc_vld_reg;

    assign acc_raddr = cnt_reg[IDX_W-1:0];

    gnfa_ram #(.WIDTH(ACC_W), .DEPTH(FEATURE_LEN)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // element pipeline: s1 has memory data, s2 holds the product, s3 the term
    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [IDX_W-1:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc2_reg, acc3_reg;
    logic signed [TERM_W-1:0] term_reg;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rnd_sum;
    logic signed [TERM_W-1:0] term_next;
    logic signed [ACC_W:0]    sum_wide;
    logic signed [ACC_W-1:0]  sum_next;
    logic signed [ACC_W-1:0]  acc1_val;

    // with normalization off, place the feature at the binary point so the
    // shared rounding step returns it unchanged
    always_comb begin
        if (norm_en_reg) begin
            prod_next = PROD_W'(signed'(feat_rdata)) * PROD_W'(signed'({1'b0, p_reg}));
        end else begin
            prod_next = PROD_W'(signed'(feat_rdata)) <<< FRAC_SHIFT;
        end
    end

    assign acc1_val  = acc_vld_reg[s1_idx_reg] ? signed'(acc_rdata) : '0;
    assign rnd_sum   = prod_reg + (PROD_W'(1) <<< (FRAC_SHIFT - 1));
    assign term_next = rnd_sum[PROD_W-1:FRAC_SHIFT];
    assign sum_wide  = (ACC_W+1)'(acc3_reg) + (ACC_W+1)'(term_reg);

    always_comb begin
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            sum_next = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                       : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[ACC_W-1:0];
        end
    end

    assign acc_we    = s3_vld_reg;
    assign acc_waddr = s3_idx_reg;
    assign acc_wdata = sum_next;

    // sequencer strobes
    logic issue;
    logic drained;
    logic emit_go;
    logic emit_last;

    assign issue     = (state_reg == ST_ACC) && (cnt_reg < CNT_W'(FEATURE_LEN));
    assign drained   = !issue && !s1_vld_reg && !s2_vld_reg && !s3_vld_reg;
    assign emit_go   = (state_reg == ST_EMIT_WR) && (!m_tvalid || m_tready);
    assign emit_last = (cnt_reg == CNT_W'(NUM_EMIT - 1));

    assign feat_re = issue;
    assign acc_re  = issue || (state_reg == ST_EMIT_RD);
    assign norm_re = (state_reg == ST_NORM_SRC) || (state_reg == ST_NORM_NBR);
    assign norm_raddr = (state_reg == ST_NORM_SRC) ? NV_W'(vid_reg) : NV_W'(nid_reg);

    // output register
    logic [9:0]        out_vertex_reg;
    logic [3:0]        out_index_reg;
    logic [ACC_W-1:0]  out_value_reg;
    logic              out_last_reg;
    logic              m_tvalid_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b0, out_value_reg, out_index_reg, out_vertex_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            acc_vld_reg  <= '0;
            norm_en_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
        end else begin
            if (cfg_write && (paddr[2] == REG_NORM_EN)) begin
                norm_en_reg <= pwdata[0];
            end

            // pipeline advance
            s1_vld_reg <= issue;
            s1_idx_reg <= cnt_reg[IDX_W-1:0];
            s2_vld_reg <= s1_vld_reg;
            s2_idx_reg <= s1_idx_reg;
            prod_reg   <= prod_next;
            acc2_reg   <= acc1_val;
            s3_vld_reg <= s2_vld_reg;
            s3_idx_reg <= s2_idx_reg;
            term_reg   <= term_next;
            acc3_reg   <= acc2_reg;
            if (s3_vld_reg) begin
                acc_vld_reg[s3_idx_reg] <= 1'b1;
            end

            // drop the taken item unless the next one loads in its place
            if (m_tvalid_reg && m_tready && !emit_go) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (s_accept && (in_action == ACT_GATHER)) begin
                        vid_reg  <= in_vertex;
                        nid_reg  <= in_neighbor;
                        last_reg <= s_tlast;
                        if (in_has_edge && in_nid_ok) begin
                            state_reg <= ST_NORM_SRC;
                        end else if (s_tlast) begin
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                ST_NORM_SRC: begin
                    state_reg <= ST_NORM_NBR;
                end
                ST_NORM_NBR: begin
                    na_reg    <= src_ok ? norm_rdata : '0;
                    state_reg <= ST_NORM_MUL;
                end
                ST_NORM_MUL: begin
                    p_reg     <= P_W'(na_reg) * P_W'(norm_rdata);
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (issue) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end else if (drained) begin
                        cnt_reg   <= '0;
                        state_reg <= last_reg ? ST_EMIT_RD : ST_IDLE;
                    end
                end
                ST_EMIT_RD: begin
                    state_reg <= ST_EMIT_WR;
                end
                ST_EMIT_WR: begin
                    if (emit_go) begin
                        // load the result item and hold it until taken
                        m_tvalid_reg   <= 1'b1;
                        out_vertex_reg <= vid_reg;
                        out_index_reg  <= 4'(cnt_reg);
                        out_value_reg  <= acc_vld_reg[cnt_reg[IDX_W-1:0]] ? acc_rdata : '0;
                        out_last_reg   <= emit_last;
                        if (emit_last) begin
                            acc_vld_reg <= '0;
                            cnt_reg     <= '0;
                            state_reg   <= ST_IDLE;
                        end else begin
                            cnt_reg   <= cnt_reg + CNT_W'(1);
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // input is taken only with the element pipeline empty
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(s1_vld_reg || s2_vld_reg || s3_vld_reg))
        else $error("item accepted while element pipeline busy");

    // read-modify-write never overlaps on one accumulator entry
    a_acc_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_we && acc_re) |-> (acc_waddr != acc_raddr))
        else $error("accumulator read and write hit the same entry");

    // the accumulator is empty once the final element of a row is loaded
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_go && emit_last) |=> (acc_vld_reg == '0) && m_tvalid && m_tlast)
        else $error("accumulator not cleared after row read-out");

    // a new result is loaded only into a free or draining output register
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten while stalled");

endmodule
